@@ hw/rtl/ffra_pkg.sv @@
// Shared constants, codes and types of the first-fit run allocator.
package ffra_pkg;

	localparam int ROWS_DEF    = 8;
	localparam int UNITS_DEF   = 64;
	localparam int TICKETS_DEF = 64;

	localparam int KIND_W     = 2;
	localparam int RUN_LEN_W  = 7;
	localparam int RATE_W     = 16;
	localparam int HANDLE_W   = 6;
	localparam int STATUS_W   = 3;
	localparam int ROW_OUT_W  = 3;
	localparam int START_W    = 6;
	localparam int PRICE_W    = 48;
	localparam int TICK_W     = 32;

	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_ROWS_W  = 4;
	localparam int CFG_UNITS_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNITS_PER_ROW = 1'd1;

	localparam logic [CFG_ROWS_W-1:0]  ROWS_IN_USE_RST   = 4'd8;
	localparam logic [CFG_UNITS_W-1:0] UNITS_PER_ROW_RST = 7'd64;

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_RUN     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;

	localparam int SLOT_GRP  = 16;
	localparam int GRP_OFF_W = 4;

	typedef struct packed {
		logic                 hit;
		logic [GRP_OFF_W-1:0] offset;
	} slot_probe_t;

endpackage

@@ hw/rtl/ffra_run_unit.sv @@
// Shared run matcher: first free run of a given length in one row, and the run mask.
module ffra_run_unit #(
	parameter int UNITS = ffra_pkg::UNITS_DEF,
	localparam int CNT_W = $clog2(UNITS + 1),
	localparam int UIDX_W = $clog2(UNITS)
) (
	input  logic [UNITS-1:0]  occ_word,
	input  logic [CNT_W-1:0]  need,
	input  logic [CNT_W-1:0]  nunits,
	input  logic [UIDX_W-1:0] start,
	output logic              hit,
	output logic [UIDX_W-1:0] first,
	output logic [UNITS-1:0]  run_mask
);

	logic [UNITS-1:0] avail;
	logic [UNITS-1:0] len_mask;
	logic [UNITS-1:0] fit;

	always_comb begin
		for (int i = 0; i < UNITS; i++) begin
			len_mask[i] = (CNT_W'(i) < need);
			avail[i]    = !occ_word[i] && (CNT_W'(i) < nunits);
		end
	end

	always_comb begin
		for (int s = 0; s < UNITS; s++) begin
			fit[s] = &((avail >> s) | ~len_mask);
		end
	end

	always_comb begin
		first = '0;
		for (int s = UNITS - 1; s >= 0; s--) begin
			if (fit[s]) begin
				first = UIDX_W'(s);
			end
		end
	end

	assign hit      = |fit;
	assign run_mask = len_mask << start;

endmodule

@@ hw/rtl/ffra_occ_mem.sv @@
// Occupancy memory: one word per row, with per-row valid bits so rows read as free after reset.
module ffra_occ_mem #(
	parameter int ROWS = ffra_pkg::ROWS_DEF,
	parameter int UNITS = ffra_pkg::UNITS_DEF,
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [ROW_W-1:0] rd_addr,
	output logic [UNITS-1:0] rd_data,
	input  logic             wr_en,
	input  logic [ROW_W-1:0] wr_addr,
	input  logic [UNITS-1:0] wr_data
);

	logic [UNITS-1:0] mem [ROWS];
	logic [ROWS-1:0]  row_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= row_valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

endmodule

@@ hw/rtl/ffra_tkt_store.sv @@
// Ticket slots: valid bits, free-slot probe over one group per cycle, and the record memory.
module ffra_tkt_store #(
	parameter int TICKETS = ffra_pkg::TICKETS_DEF,
	parameter int REC_W = 64,
	localparam int SLOT_W = (TICKETS > 1) ? $clog2(TICKETS) : 1,
	localparam int NGRP = (TICKETS + ffra_pkg::SLOT_GRP - 1) / ffra_pkg::SLOT_GRP,
	localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [GRP_W-1:0]      probe_grp,
	output ffra_pkg::slot_probe_t probe,
	input  logic [SLOT_W-1:0]     chk_addr,
	output logic                  chk_valid,
	input  logic                  set_en,
	input  logic                  clr_en,
	input  logic [SLOT_W-1:0]     wr_addr,
	input  logic [REC_W-1:0]      wr_data,
	input  logic [SLOT_W-1:0]     rd_addr,
	output logic [REC_W-1:0]      rd_data
);

	localparam int GRP   = ffra_pkg::SLOT_GRP;
	localparam int OFF_W = ffra_pkg::GRP_OFF_W;

	logic [TICKETS-1:0]    valid_q;
	logic [NGRP*GRP-1:0]   valid_pad;
	logic [GRP-1:0]        grp_busy;
	logic [REC_W-1:0]      rec_mem [TICKETS];

	always_comb begin
		valid_pad              = '1;
		valid_pad[TICKETS-1:0] = valid_q;
	end

	assign grp_busy  = valid_pad[probe_grp * GRP +: GRP];
	assign chk_valid = valid_q[chk_addr];

	always_comb begin
		probe.hit    = ~&grp_busy;
		probe.offset = '0;
		for (int i = GRP - 1; i >= 0; i--) begin
			if (!grp_busy[i]) begin
				probe.offset = OFF_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (set_en) begin
			valid_q[wr_addr] <= 1'b1;
		end else if (clr_en) begin
			valid_q[wr_addr] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (set_en) begin
			rec_mem[wr_addr] <= wr_data;
		end
		rd_data <= rec_mem[rd_addr];
	end

	a_set_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(set_en && clr_en))
		else $error("Ticket slot set and cleared in the same cycle.");

	a_set_takes: assert property (@(posedge clk) disable iff (!arst_n)
		set_en |=> valid_q[$past(wr_addr)])
		else $error("Allocated ticket slot is not marked valid.");

	a_clr_takes: assert property (@(posedge clk) disable iff (!arst_n)
		clr_en |=> !valid_q[$past(wr_addr)])
		else $error("Released ticket slot is still marked valid.");

endmodule

@@ hw/rtl/first_fit_run_allocator.sv @@
// First-fit run allocator top level: sequencer, configuration, time counter and result register.
// A tick or an unknown kind is done at acceptance. A release of a live ticket passes through
// the acceptance, the slot check with the record read, the occupancy row read together with the
// price multiply, the row write, and the hand-off to the output register; a release of a handle
// that is not live goes from the slot check straight to the hand-off. An allocate that succeeds
// passes through the acceptance, the probe of ticket groups (sixteen slots each, at most
// ceil(TICKETS/16) groups), the scan of rows (at most the smaller of rows_in_use and ROWS), the
// row write and the hand-off; each row scanned costs one read of the occupancy memory and one
// pass through the shared run matcher. An allocate that finds no run skips the row write, one
// with a zero or too long run length or no rows in use also skips the row scan, and one that
// finds the ticket table full probes every group and then goes to the hand-off. A finished
// result waits in the output register while the next transaction is accepted; while the previous
// result still waits there, the block holds in its hand-off state until that result leaves.
// Occupancy rows and ticket slots are free right after reset, with no clearing pass.
module first_fit_run_allocator #(
	parameter int ROWS = ffra_pkg::ROWS_DEF,
	parameter int UNITS = ffra_pkg::UNITS_DEF,
	parameter int TICKETS = ffra_pkg::TICKETS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ffra_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ffra_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ffra_pkg::KIND_W-1:0]       kind,
	input  logic [ffra_pkg::RUN_LEN_W-1:0]    run_length,
	input  logic [ffra_pkg::RATE_W-1:0]       rate,
	input  logic [ffra_pkg::HANDLE_W-1:0]     release_handle,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ffra_pkg::STATUS_W-1:0]     status,
	output logic [ffra_pkg::HANDLE_W-1:0]     handle,
	output logic [ffra_pkg::ROW_OUT_W-1:0]    row,
	output logic [ffra_pkg::START_W-1:0]      start_unit,
	output logic [ffra_pkg::PRICE_W-1:0]      price
);

	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ROWC_W  = $clog2(ROWS + 1);
	localparam int CNT_W   = $clog2(UNITS + 1);
	localparam int UIDX_W  = $clog2(UNITS);
	localparam int SLOT_W  = (TICKETS > 1) ? $clog2(TICKETS) : 1;
	localparam int NGRP    = (TICKETS + ffra_pkg::SLOT_GRP - 1) / ffra_pkg::SLOT_GRP;
	localparam int GRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int TICK_W  = ffra_pkg::TICK_W;
	localparam int RATE_W  = ffra_pkg::RATE_W;
	localparam int PRICE_W = ffra_pkg::PRICE_W;
	localparam int LEN_W   = ffra_pkg::RUN_LEN_W;
	localparam int HND_W   = ffra_pkg::HANDLE_W;
	localparam int ROWO_W  = ffra_pkg::ROW_OUT_W;
	localparam int STO_W   = ffra_pkg::START_W;
	localparam int REC_W   = ROW_W + UIDX_W + CNT_W + RATE_W + TICK_W;
	localparam int RATE_LO = TICK_W;
	localparam int LEN_LO  = RATE_LO + RATE_W;
	localparam int STRT_LO = LEN_LO + CNT_W;
	localparam int ROW_LO  = STRT_LO + UIDX_W;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SLOT     = 4'd1;
	localparam logic [3:0] S_ROW_RD   = 4'd2;
	localparam logic [3:0] S_ROW_EV   = 4'd3;
	localparam logic [3:0] S_ALLOC_WR = 4'd4;
	localparam logic [3:0] S_REL_RD   = 4'd5;
	localparam logic [3:0] S_REL_OCC  = 4'd6;
	localparam logic [3:0] S_REL_WR   = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0]                          state_q;
	logic [ffra_pkg::CFG_ROWS_W-1:0]     cfg_rows_q;
	logic [ffra_pkg::CFG_UNITS_W-1:0]    cfg_units_q;
	logic [TICK_W-1:0]                   tick_q;
	logic [LEN_W-1:0]                    need_q;
	logic [RATE_W-1:0]                   rate_q;
	logic [HND_W-1:0]                    hnd_q;
	logic [SLOT_W-1:0]                   slot_q;
	logic [GRP_W-1:0]                    grp_q;
	logic [ROWC_W-1:0]                   row_q;
	logic [UIDX_W-1:0]                   start_q;
	logic [PRICE_W-1:0]                  price_q;
	logic [ffra_pkg::STATUS_W-1:0]       res_status_q;
	logic [HND_W-1:0]                    res_handle_q;
	logic [ROWO_W-1:0]                   res_row_q;
	logic [STO_W-1:0]                    res_start_q;
	logic                                out_valid_q;
	logic [ffra_pkg::STATUS_W-1:0]       out_status_q;
	logic [HND_W-1:0]                    out_handle_q;
	logic [ROWO_W-1:0]                   out_row_q;
	logic [STO_W-1:0]                    out_start_q;
	logic [PRICE_W-1:0]                  out_price_q;

	logic [ROWC_W-1:0]     nrows;
	logic [CNT_W-1:0]      nunits;
	logic                  occ_rd_en;
	logic [ROW_W-1:0]      occ_rd_addr;
	logic [UNITS-1:0]      occ_rd_data;
	logic                  occ_wr_en;
	logic [UNITS-1:0]      occ_wr_data;
	logic                  run_hit;
	logic [UIDX_W-1:0]     run_first;
	logic [UNITS-1:0]      run_mask;
	ffra_pkg::slot_probe_t probe;
	logic                  chk_valid;
	logic [REC_W-1:0]      rec_wr;
	logic [REC_W-1:0]      rec_rd;
	logic [ROW_W-1:0]      rec_row;
	logic [UIDX_W-1:0]     rec_start;
	logic [CNT_W-1:0]      rec_len;
	logic [RATE_W-1:0]     rec_rate;
	logic [TICK_W-1:0]     rec_entry;
	logic [TICK_W-1:0]     elapsed;
	logic [PRICE_W-1:0]    product;
	logic                  out_load;

	assign nrows  = (32'(cfg_rows_q) < ROWS) ? ROWC_W'(cfg_rows_q) : ROWC_W'(ROWS);
	assign nunits = (32'(cfg_units_q) < UNITS) ? CNT_W'(cfg_units_q) : CNT_W'(UNITS);

	assign rec_entry = rec_rd[TICK_W-1:0];
	assign rec_rate  = rec_rd[RATE_LO +: RATE_W];
	assign rec_len   = rec_rd[LEN_LO +: CNT_W];
	assign rec_start = rec_rd[STRT_LO +: UIDX_W];
	assign rec_row   = rec_rd[ROW_LO +: ROW_W];
	assign rec_wr    = {ROW_W'(row_q), start_q, CNT_W'(need_q), rate_q, tick_q};
	assign elapsed   = tick_q - rec_entry;
	assign product   = elapsed * rec_rate;

	assign occ_rd_en   = (state_q == S_ROW_RD) || (state_q == S_REL_OCC);
	assign occ_rd_addr = (state_q == S_REL_OCC) ? rec_row : ROW_W'(row_q);
	assign occ_wr_en   = (state_q == S_ALLOC_WR) || (state_q == S_REL_WR);
	assign occ_wr_data = (state_q == S_ALLOC_WR) ? (occ_rd_data | run_mask)
	                                             : (occ_rd_data & ~run_mask);

	assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign handle     = out_handle_q;
	assign row        = out_row_q;
	assign start_unit = out_start_q;
	assign price      = out_price_q;

	ffra_occ_mem #(
		.ROWS (ROWS),
		.UNITS(UNITS)
	) u_occ_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (occ_rd_en),
		.rd_addr(occ_rd_addr),
		.rd_data(occ_rd_data),
		.wr_en  (occ_wr_en),
		.wr_addr(ROW_W'(row_q)),
		.wr_data(occ_wr_data)
	);

	ffra_run_unit #(
		.UNITS(UNITS)
	) u_run_unit (
		.occ_word(occ_rd_data),
		.need    (CNT_W'(need_q)),
		.nunits  (nunits),
		.start   (start_q),
		.hit     (run_hit),
		.first   (run_first),
		.run_mask(run_mask)
	);

	ffra_tkt_store #(
		.TICKETS(TICKETS),
		.REC_W  (REC_W)
	) u_tkt_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.probe_grp(grp_q),
		.probe    (probe),
		.chk_addr (slot_q),
		.chk_valid(chk_valid),
		.set_en   (state_q == S_ALLOC_WR),
		.clr_en   (state_q == S_REL_WR),
		.wr_addr  (slot_q),
		.wr_data  (rec_wr),
		.rd_addr  (slot_q),
		.rd_data  (rec_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_rows_q  <= ffra_pkg::ROWS_IN_USE_RST;
			cfg_units_q <= ffra_pkg::UNITS_PER_ROW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ffra_pkg::CFG_ROWS_IN_USE: begin
					cfg_rows_q <= cfg_data[ffra_pkg::CFG_ROWS_W-1:0];
				end
				ffra_pkg::CFG_UNITS_PER_ROW: begin
					cfg_units_q <= cfg_data[ffra_pkg::CFG_UNITS_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tick_q       <= '0;
			need_q       <= '0;
			rate_q       <= '0;
			hnd_q        <= '0;
			slot_q       <= '0;
			grp_q        <= '0;
			row_q        <= '0;
			start_q      <= '0;
			price_q      <= '0;
			res_status_q <= '0;
			res_handle_q <= '0;
			res_row_q    <= '0;
			res_start_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_handle_q <= '0;
			out_row_q    <= '0;
			out_start_q  <= '0;
			out_price_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						need_q <= run_length;
						rate_q <= rate;
						hnd_q  <= release_handle;
						slot_q <= SLOT_W'(release_handle);
						grp_q  <= '0;
						case (kind)
							ffra_pkg::KIND_ALLOC:   state_q <= S_SLOT;
							ffra_pkg::KIND_RELEASE: state_q <= S_REL_RD;
							ffra_pkg::KIND_TICK:    tick_q <= tick_q + 1'b1;
							default: ;
						endcase
					end
				end
				S_SLOT: begin
					if (probe.hit) begin
						slot_q <= SLOT_W'({grp_q, probe.offset});
						row_q  <= '0;
						if (need_q == '0 || 32'(need_q) > 32'(nunits) || nrows == '0) begin
							res_status_q <= ffra_pkg::ST_NO_RUN;
							res_handle_q <= '0;
							res_row_q    <= '0;
							res_start_q  <= '0;
							price_q      <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_ROW_RD;
						end
					end else if (32'(grp_q) == NGRP - 1) begin
						res_status_q <= ffra_pkg::ST_TABLE_FULL;
						res_handle_q <= '0;
						res_row_q    <= '0;
						res_start_q  <= '0;
						price_q      <= '0;
						state_q      <= S_DONE;
					end else begin
						grp_q <= grp_q + 1'b1;
					end
				end
				S_ROW_RD: begin
					state_q <= S_ROW_EV;
				end
				S_ROW_EV: begin
					if (run_hit) begin
						start_q <= run_first;
						state_q <= S_ALLOC_WR;
					end else if (32'(row_q) + 32'd1 >= 32'(nrows)) begin
						res_status_q <= ffra_pkg::ST_NO_RUN;
						res_handle_q <= '0;
						res_row_q    <= '0;
						res_start_q  <= '0;
						price_q      <= '0;
						state_q      <= S_DONE;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_ROW_RD;
					end
				end
				S_ALLOC_WR: begin
					res_status_q <= ffra_pkg::ST_ALLOCATED;
					res_handle_q <= HND_W'(slot_q);
					res_row_q    <= ROWO_W'(row_q);
					res_start_q  <= STO_W'(start_q);
					price_q      <= '0;
					state_q      <= S_DONE;
				end
				S_REL_RD: begin
					if (32'(hnd_q) >= TICKETS || !chk_valid) begin
						res_status_q <= ffra_pkg::ST_BAD_HANDLE;
						res_handle_q <= hnd_q;
						res_row_q    <= '0;
						res_start_q  <= '0;
						price_q      <= '0;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_REL_OCC;
					end
				end
				S_REL_OCC: begin
					row_q   <= ROWC_W'(rec_row);
					start_q <= rec_start;
					need_q  <= LEN_W'(rec_len);
					price_q <= product;
					state_q <= S_REL_WR;
				end
				S_REL_WR: begin
					res_status_q <= ffra_pkg::ST_RELEASED;
					res_handle_q <= hnd_q;
					res_row_q    <= ROWO_W'(row_q);
					res_start_q  <= STO_W'(start_q);
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_handle_q <= res_handle_q;
						out_row_q    <= res_row_q;
						out_start_q  <= res_start_q;
						out_price_q  <= price_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_run_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC_WR) |-> (32'(start_q) + 32'(need_q) <= 32'(nunits)))
		else $error("Allocated run extends past the units in use.");

	a_release_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REL_WR) |-> chk_valid)
		else $error("Release writes back a slot that is not valid.");

	a_price_only_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ffra_pkg::ST_RELEASED) |-> (out_price_q == '0))
		else $error("Nonzero price on a transaction other than a release.");

endmodule
